@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/gcc_pkg.sv @@
// shared types and constants for the graph cycle check block
package gcc_pkg;

  localparam int ROW_WIDTH   = 16;
  localparam int INDEX_WIDTH = 4;
  localparam int COUNT_WIDTH = 5;
  localparam int LANES       = 4;

  // input transaction
  typedef struct packed {
    logic [INDEX_WIDTH-1:0] row_index;
    logic [ROW_WIDTH-1:0]   row_bits;
    logic                   last_row;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic                   is_acyclic;
    logic [COUNT_WIDTH-1:0] remaining_nodes;
  } out_item_t;

  // row write port into the lanes
  typedef struct packed {
    logic                   en;
    logic [INDEX_WIDTH-1:0] index;
    logic [ROW_WIDTH-1:0]   data;
  } row_wr_t;

  // merge stage findings
  typedef struct packed {
    logic [ROW_WIDTH-1:0] next_mask;
    logic                 converged;
  } merge_t;

endpackage

@@ rtl/graph_cycle_check.sv @@
// Graph cycle check by repeated removal of source nodes, rows held in parallel lanes.
// A row without last_row is taken and the input stays open.
// A last row starts the check: each elimination round is a lane OR step, then a merge step,
// rounds = rounds that remove a node + 1 (at most node_count + 1); the result is registered
// as the sequencer leaves ST_FIN, and the input is stalled until then.
// Sync reset clears control, node_count becomes 16, the stored rows keep no reset value.
module graph_cycle_check #(
  parameter int MAX_NODES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gcc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gcc_pkg::out_item_t              out_data,
  input  logic                            cfg_write,
  input  logic [gcc_pkg::COUNT_WIDTH-1:0] cfg_data
);
  import gcc_pkg::*;

  localparam int ROWS = (MAX_NODES < ROW_WIDTH) ? MAX_NODES : ROW_WIDTH;
  localparam int RPL  = (ROWS + LANES - 1) / LANES;
  localparam logic [COUNT_WIDTH-1:0] ROWS_LIM   = COUNT_WIDTH'(ROWS);
  localparam logic [COUNT_WIDTH-1:0] NODES_INIT = COUNT_WIDTH'(ROW_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LANE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state;
  logic [ROW_WIDTH-1:0]   active;
  logic [COUNT_WIDTH-1:0] node_count;
  logic [COUNT_WIDTH-1:0] nodes_used;
  logic [ROW_WIDTH-1:0]   init_mask;
  logic [COUNT_WIDTH-1:0] remain;
  logic                   in_take;
  logic                   out_free;
  row_wr_t                row_wr;
  merge_t                 merge;
  logic [ROW_WIDTH-1:0]   lane_or [LANES];

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // row write into the lanes
  always_comb begin
    row_wr.en    = in_take;
    row_wr.index = in_data.row_index;
    row_wr.data  = in_data.row_bits;
  end

  // nodes in use, bounded by the stored rows
  assign nodes_used = (node_count > ROWS_LIM) ? ROWS_LIM : node_count;

  // all in-use nodes start active
  always_comb begin
    for (int i = 0; i < ROW_WIDTH; i++) begin
      init_mask[i] = (COUNT_WIDTH'(i) < nodes_used);
    end
  end

  // lanes, each owning a slice of rows
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int FIRST = l * RPL;
    localparam int LEFT  = ROWS - FIRST;
    if (LEFT > 0) begin : g_on
      gcc_lane #(
        .FIRST_ROW (FIRST),
        .NUM_ROWS  ((LEFT < RPL) ? LEFT : RPL)
      ) u_lane (
        .clk     (clk),
        .row_wr  (row_wr),
        .active  (active),
        .lane_or (lane_or[l])
      );
    end else begin : g_off
      assign lane_or[l] = '0;
    end
  end

  gcc_merge u_merge (
    .lane_or (lane_or),
    .active  (active),
    .merge   (merge)
  );

  assign remain = COUNT_WIDTH'($countones(active));

  // control: config register, sequencer, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      node_count <= NODES_INIT;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take && in_data.last_row) begin
            active <= init_mask;
            state  <= ST_LANE;
          end
        end
        ST_LANE: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (merge.converged) begin
            state <= ST_FIN;
          end else begin
            active <= merge.next_mask;
            state  <= ST_LANE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      out_data.is_acyclic      <= (remain == '0);
      out_data.remaining_nodes <= remain;
    end
  end

endmodule

@@ rtl/gcc_lane.sv @@
// one lane: holds a slice of adjacency rows and ORs the rows of active nodes
module gcc_lane #(
  parameter int FIRST_ROW = 0,
  parameter int NUM_ROWS  = 4
) (
  input  logic                          clk,
  input  gcc_pkg::row_wr_t              row_wr,
  input  logic [gcc_pkg::ROW_WIDTH-1:0] active,
  output logic [gcc_pkg::ROW_WIDTH-1:0] lane_or
);
  import gcc_pkg::*;

  logic [ROW_WIDTH-1:0] rows [NUM_ROWS];
  logic [ROW_WIDTH-1:0] lane_or_next;

  // row storage, each row answers to its own node index
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (row_wr.en && (row_wr.index == INDEX_WIDTH'(FIRST_ROW + k))) begin
        rows[k] <= row_wr.data;
      end
    end
  end

  // incoming edges from the active nodes of this slice
  always_comb begin
    lane_or_next = '0;
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (active[FIRST_ROW + k]) begin
        lane_or_next = lane_or_next | rows[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_or <= lane_or_next;
  end

endmodule

@@ rtl/gcc_merge.sv @@
// merge stage: combines lane results into the next active set
module gcc_merge (
  input  logic [gcc_pkg::ROW_WIDTH-1:0] lane_or [gcc_pkg::LANES],
  input  logic [gcc_pkg::ROW_WIDTH-1:0] active,
  output gcc_pkg::merge_t               merge
);
  import gcc_pkg::*;

  logic [ROW_WIDTH-1:0] incoming;

  // union of incoming edges over all lanes
  always_comb begin
    incoming = '0;
    for (int l = 0; l < LANES; l++) begin
      incoming = incoming | lane_or[l];
    end
  end

  // keep only nodes that still have an active predecessor
  always_comb begin
    merge.next_mask = active & incoming;
    merge.converged = (merge.next_mask == active);
  end

endmodule

@@ rtl/gcc_check.sv @@
// port-level checker for the graph cycle check, bound to the top level
`include "assert_macros.svh"

module gcc_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input gcc_pkg::in_item_t               in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input gcc_pkg::out_item_t              out_data
);
  import gcc_pkg::*;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // acyclic flag agrees with the remaining count
  `ASSERT_SAME(a_flag_count, out_valid, out_data.is_acyclic == (out_data.remaining_nodes == '0))

  // never more nodes left than a row can hold
  `ASSERT_SAME(a_count_max, out_valid, out_data.remaining_nodes <= COUNT_WIDTH'(ROW_WIDTH))

  // a final row starts the check and closes the input
  `ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_data.last_row, in_stall)

  // a plain row leaves the input open
  `ASSERT_NEXT(a_row_open, in_valid && !in_stall && !in_data.last_row, !in_stall)

endmodule

bind graph_cycle_check gcc_check u_check (.*);
